// ===== rtl/ata_s2t_pkg.sv =====
// Package for the ATA sector-to-task-file block: constants, pipeline types and
// the divider step function. No dependencies.
package ata_s2t_pkg;

  localparam int SECTOR_BITS = 48;
  localparam int DIV_W       = 48;
  localparam int CHUNK       = 8;
  localparam int N_CHUNK     = DIV_W / CHUNK;
  // Stage 0 input, N_CHUNK stages per division, one output stage.
  localparam int NST         = 2 * N_CHUNK + 2;

  localparam logic [DIV_W-1:0] SECTOR_MASK =
    (SECTOR_BITS >= DIV_W) ? {DIV_W{1'b1}} : ((DIV_W'(1) << SECTOR_BITS) - DIV_W'(1));

  localparam logic [1:0] MODE_CHS     = 2'd0;
  localparam logic [1:0] MODE_LBA28   = 2'd1;
  localparam logic [1:0] MODE_LBA48   = 2'd2;
  localparam logic [1:0] MODE_INVALID = 2'd3;

  localparam logic [2:0] REG_MODE  = 3'd0;
  localparam logic [2:0] REG_SPT   = 3'd1;
  localparam logic [2:0] REG_HEADS = 3'd2;
  localparam logic [2:0] REG_TOTAL = 3'd3;
  localparam logic [2:0] REG_SLAVE = 3'd4;

  localparam logic [7:0] DEV_BASE     = 8'hA0;
  localparam logic [7:0] DEV_LBA      = 8'h40;
  localparam logic [7:0] DEV_SLAVE    = 8'h10;
  localparam logic [7:0] CMD_READ     = 8'h20;
  localparam logic [7:0] CMD_READ_EXT = 8'h24;
  localparam logic [7:0] NIBBLE       = 8'h0F;

  typedef struct packed {
    logic [DIV_W-1:0] s;
    logic [DIV_W-1:0] q1;
    logic [7:0]       r1;
    logic [DIV_W-1:0] q2;
    logic [7:0]       r2;
  } pipe_t;

  typedef struct packed {
    logic [DIV_W-1:0] quo;
    logic [7:0]       rem;
  } div_t;

  // Eight restoring division steps over one byte of the dividend.
  function automatic div_t div_chunk(logic [7:0] rem_in, logic [DIV_W-1:0] quo_in,
                                     logic [CHUNK-1:0] bits, logic [7:0] dvs);
    div_t       res;
    logic [8:0] t;
    logic [7:0] rem;
    logic [DIV_W-1:0] quo;
    rem = rem_in;
    quo = quo_in;
    for (int i = CHUNK - 1; i >= 0; i--) begin
      t = {rem, bits[i]};
      if (t >= {1'b0, dvs}) begin
        t   = t - {1'b0, dvs};
        quo = {quo[DIV_W-2:0], 1'b1};
      end else begin
        quo = {quo[DIV_W-2:0], 1'b0};
      end
      rem = t[7:0];
    end
    res.quo = quo;
    res.rem = rem;
    return res;
  endfunction

endpackage

// ===== rtl/ata_sector_to_taskfile.sv =====
// Top level of the ATA sector-to-task-file translator: a pipelined CHS divider
// and the task-file byte formatter. Depends on ata_s2t_pkg.
//
//  channel | ports                          | direction
//  in      | in_valid in_ready in_sector    | sector number beats in
//  out     | out_valid out_ready out_*      | task-file beats out
//  cfg     | cfg_valid cfg_ready cfg_index  | register writes in (cfg_data)
//
// A beat passes fourteen registers: one input register, six stages of eight
// divider steps for the sector over the sectors per track, six more for the
// track over the head count, and the output register. The input register is
// loaded at the accepting edge. A new beat enters every cycle unless a stall
// has backed up to stage 0. Reset (synchronous, rst_n low) empties the pipeline
// and loads the register defaults. A stall at the output lets bubbles close up
// behind it; each stage holds while the one after it is full and blocked.
module ata_sector_to_taskfile
  import ata_s2t_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [47:0] in_sector,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_error,
  output logic [7:0]  out_count_byte,
  output logic [7:0]  out_addr_low,
  output logic [7:0]  out_addr_mid,
  output logic [7:0]  out_addr_high,
  output logic [7:0]  out_ext_low,
  output logic [7:0]  out_ext_mid,
  output logic [7:0]  out_ext_high,
  output logic [7:0]  out_device_byte,
  output logic [7:0]  out_command_byte,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [47:0] cfg_data
);

  // Configuration registers. The user must change them only while the pipeline
  // is empty; the block does not enforce it. Every stage reads them directly.
  logic [1:0]  mode_r;
  logic [7:0]  spt_r;
  logic [4:0]  heads_r;
  logic [47:0] total_r;
  logic        slave_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_CHS;
      spt_r   <= 8'd63;
      heads_r <= 5'd16;
      total_r <= '0;
      slave_r <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_MODE:  mode_r  <= cfg_data[1:0];
        REG_SPT:   spt_r   <= cfg_data[7:0];
        REG_HEADS: heads_r <= cfg_data[4:0];
        REG_TOTAL: total_r <= cfg_data;
        REG_SLAVE: slave_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Pipeline: stage 0 holds the sector, stages 1..N_CHUNK divide by the
  // sectors per track, the next N_CHUNK divide the track by the head count.
  logic        v_r   [NST-1];
  pipe_t       st_r  [NST-1];
  pipe_t       st_nxt[NST-1];
  logic        free  [NST];

  // A stage can take a beat when it is empty or its own beat moves on.
  always_comb begin
    free[NST-1] = !out_valid || out_ready;
    for (int i = NST - 2; i >= 0; i--) begin
      free[i] = !v_r[i] || free[i+1];
    end
  end

  assign in_ready = free[0];

  always_comb begin
    st_nxt[0]    = '0;
    st_nxt[0].s  = in_sector & SECTOR_MASK;
  end

  for (genvar k = 1; k <= N_CHUNK; k++) begin : g_div1
    div_t d;
    always_comb begin
      d = div_chunk(st_r[k-1].r1, st_r[k-1].q1,
                    st_r[k-1].s[DIV_W-1-CHUNK*(k-1) -: CHUNK], spt_r);
      st_nxt[k]    = st_r[k-1];
      st_nxt[k].q1 = d.quo;
      st_nxt[k].r1 = d.rem;
    end
  end

  for (genvar k = 1; k <= N_CHUNK; k++) begin : g_div2
    div_t d;
    always_comb begin
      d = div_chunk(st_r[N_CHUNK+k-1].r2, st_r[N_CHUNK+k-1].q2,
                    st_r[N_CHUNK+k-1].q1[DIV_W-1-CHUNK*(k-1) -: CHUNK],
                    {3'b000, heads_r});
      st_nxt[N_CHUNK+k]    = st_r[N_CHUNK+k-1];
      st_nxt[N_CHUNK+k].q2 = d.quo;
      st_nxt[N_CHUNK+k].r2 = d.rem;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NST - 1; i++) v_r[i] <= 1'b0;
    end else begin
      v_r[0] <= free[0] ? in_valid : v_r[0];
      for (int i = 1; i < NST - 1; i++) begin
        if (free[i]) v_r[i] <= v_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NST - 1; i++) begin
      if (free[i]) st_r[i] <= st_nxt[i];
    end
  end

  // Formatter on the last divider stage, registered into the output.
  pipe_t      last;
  logic       bad;
  logic [7:0] slv;
  logic [7:0] num;
  logic       err_nxt;
  logic [7:0] lo_nxt, mid_nxt, hi_nxt, xl_nxt, xm_nxt, xh_nxt, dev_nxt, cmd_nxt;

  always_comb begin
    last = st_r[NST-2];
    slv  = slave_r ? DEV_SLAVE : 8'h00;
    num  = last.r1 + 8'd1;
    bad  = (last.s >= total_r) || (mode_r == MODE_INVALID) ||
           ((mode_r == MODE_CHS) && ((spt_r == 8'd0) || (heads_r == 5'd0)));
    err_nxt = bad;
    lo_nxt  = '0; mid_nxt = '0; hi_nxt = '0;
    xl_nxt  = '0; xm_nxt  = '0; xh_nxt = '0;
    dev_nxt = '0; cmd_nxt = '0;
    if (!bad) begin
      unique case (mode_r)
        MODE_CHS: begin
          lo_nxt  = num;
          mid_nxt = last.q2[7:0];
          hi_nxt  = last.q2[15:8];
          dev_nxt = DEV_BASE | (last.r2 & NIBBLE) | slv;
          cmd_nxt = CMD_READ;
        end
        MODE_LBA28: begin
          lo_nxt  = last.s[7:0];
          mid_nxt = last.s[15:8];
          hi_nxt  = last.s[23:16];
          dev_nxt = DEV_BASE | DEV_LBA | {4'h0, last.s[27:24]} | slv;
          cmd_nxt = CMD_READ;
        end
        default: begin
          lo_nxt  = last.s[7:0];
          mid_nxt = last.s[15:8];
          hi_nxt  = last.s[23:16];
          xl_nxt  = last.s[31:24];
          xm_nxt  = last.s[39:32];
          xh_nxt  = last.s[47:40];
          dev_nxt = DEV_BASE | DEV_LBA | slv;
          cmd_nxt = CMD_READ_EXT;
        end
      endcase
    end
  end

  logic out_valid_r;
  assign out_valid      = out_valid_r;
  assign out_count_byte = 8'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (free[NST-1]) begin
      out_valid_r <= v_r[NST-2];
    end
  end

  always_ff @(posedge clk) begin
    if (free[NST-1]) begin
      out_error        <= err_nxt;
      out_addr_low     <= lo_nxt;
      out_addr_mid     <= mid_nxt;
      out_addr_high    <= hi_nxt;
      out_ext_low      <= xl_nxt;
      out_ext_mid      <= xm_nxt;
      out_ext_high     <= xh_nxt;
      out_device_byte  <= dev_nxt;
      out_command_byte <= cmd_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_in_enters: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> v_r[0])
    else $error("accepted beat did not enter stage 0");

  a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_error |-> out_addr_low == 8'd0 && out_command_byte == 8'd0 &&
    out_device_byte == 8'd0)
    else $error("rejected request carries address bytes");

  a_chs_sector: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_error && mode_r == MODE_CHS |-> out_addr_low != 8'd0)
    else $error("CHS sector number is zero");

  a_hold_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_device_byte))
    else $error("stalled result changed");
`endif

endmodule
